@@ rtl/core/gas_level_indicator_with_calibration_assert.svh @@
// Assertion helpers shared by the RTL of the gas level indicator.
`ifndef GAS_LEVEL_INDICATOR_WITH_CALIBRATION_ASSERT_SVH
`define GAS_LEVEL_INDICATOR_WITH_CALIBRATION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gli_pkg.sv @@
`default_nettype none

package gli_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int LEVEL_BITS      = 4;
    localparam int ZONE_BITS       = 2;
    localparam int FB_BITS         = 3;
    localparam int PRESS_BITS      = 16;
    localparam int CFG_IDX_BITS    = 8;
    localparam int CFG_DATA_BITS   = 16;

    // The level span 9 - 1 = 8 is a power of two, so scaling is a shift.
    localparam int SCALE_SHIFT = 3;
    localparam int QUO_BITS    = SCALE_SHIFT + 1;
    localparam int STEP_BITS   = 2;
    localparam logic [QUO_BITS-1:0]   QUO_MAX   = QUO_BITS'(1 << SCALE_SHIFT);
    localparam logic [LEVEL_BITS-1:0] LEVEL_MIN = LEVEL_BITS'(1);
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = LEVEL_BITS'(9);

    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_LEVEL   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_LEVEL  = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESET_PRESS = CFG_IDX_BITS'(3);

    localparam logic [LEVEL_BITS-1:0] LOW_LEVEL_RST   = LEVEL_BITS'(4);
    localparam logic [LEVEL_BITS-1:0] HIGH_LEVEL_RST  = LEVEL_BITS'(7);
    localparam logic [PRESS_BITS-1:0] LONG_PRESS_RST  = PRESS_BITS'(10);
    localparam logic [PRESS_BITS-1:0] RESET_PRESS_RST = PRESS_BITS'(100);

    typedef enum logic [ZONE_BITS-1:0] {
        ZONE_GREEN,
        ZONE_YELLOW,
        ZONE_RED
    } t_zone;

    typedef enum logic [FB_BITS-1:0] {
        FB_NONE,
        FB_DEFAULTS,
        FB_HIGH_SET,
        FB_LOW_SET,
        FB_REJECTED
    } t_feedback;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL,
        ST_PREP,
        ST_DIV,
        ST_ZONE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] low_level;
        logic [LEVEL_BITS-1:0] high_level;
        logic [PRESS_BITS-1:0] long_press;
        logic [PRESS_BITS-1:0] reset_press;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/core/gli_if.sv @@
`default_nettype none

interface gli_in_if #(
    parameter int SAMPLE_BITS = gli_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   button_pressed;

    modport source (output valid, output sample, output button_pressed, input ready);
    modport sink   (input valid, input sample, input button_pressed, output ready);
endinterface

interface gli_out_if #(
    parameter int SAMPLE_BITS = gli_pkg::SAMPLE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic [gli_pkg::ZONE_BITS-1:0]   zone;
    logic [gli_pkg::LEVEL_BITS-1:0]  level;
    logic [gli_pkg::FB_BITS-1:0]     feedback;
    logic [SAMPLE_BITS-1:0]          cal_low_out;
    logic [SAMPLE_BITS-1:0]          cal_high_out;

    modport source (output valid, output zone, output level, output feedback,
                    output cal_low_out, output cal_high_out, input ready);
    modport sink   (input valid, input zone, input level, input feedback,
                    input cal_low_out, input cal_high_out, output ready);
endinterface

interface gli_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gli_pkg::CFG_IDX_BITS-1:0]   index;
    logic [gli_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gas_level_indicator_with_calibration.sv @@
// Gas level indicator with push-button calibration.
//
// Input channel i_in carries one beat per sensor tick: the sample and the
// button level. Output channel o_out returns exactly one beat per input
// beat: zone, level 1..9, calibration feedback and both calibration points.
// Configuration writes on i_cfg (index 0 low_level, 1 high_level,
// 2 long_press_ticks, 3 reset_press_ticks) are always accepted; they must
// only be issued while no beat is in flight.
//
// One beat is processed at a time. After acceptance the sequencer steps
// through the press counter and calibration update, clamping, the
// compare/subtract divider (four quotient bits, one per cycle, then a step
// to hand the quotient over), the zone decision and loading the output
// register. Only then does it return to idle and accept the next beat.
//
// When the receiver stalls, the next beat is still accepted and computed; the
// sequencer then waits in its final step until the output register is free.
// Synchronous reset restores the default thresholds and calibration span,
// clears the press counter, sets the last zone to green and empties o_out.
`default_nettype none

`include "gas_level_indicator_with_calibration_assert.svh"

module gas_level_indicator_with_calibration #(
    parameter int SAMPLE_BITS = gli_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gli_in_if.sink     i_in,
    gli_out_if.source  o_out,
    gli_cfg_if.sink    i_cfg
);

    localparam int NUM_BITS = SAMPLE_BITS + gli_pkg::SCALE_SHIFT;
    localparam int LB       = gli_pkg::LEVEL_BITS;

    gli_pkg::t_cfg      w_cfg;
    gli_pkg::t_state    r_state;
    gli_pkg::t_state    n_state;

    // Item registers.
    logic [SAMPLE_BITS-1:0]         r_sample;
    logic                           r_btn;
    gli_pkg::t_feedback             r_fb;
    logic                           r_empty;
    logic [LB-1:0]                  r_level;
    gli_pkg::t_zone                 r_zone;

    // Persistent state.
    logic [SAMPLE_BITS-1:0]         r_cal_low;
    logic [SAMPLE_BITS-1:0]         r_cal_high;
    logic [gli_pkg::PRESS_BITS-1:0] r_press;
    gli_pkg::t_zone                 r_last_zone;

    logic [SAMPLE_BITS-1:0]         n_cal_low;
    logic [SAMPLE_BITS-1:0]         n_cal_high;
    logic [gli_pkg::PRESS_BITS-1:0] n_press;
    gli_pkg::t_feedback             n_fb;

    // Output register.
    logic                           r_out_valid;
    gli_pkg::t_zone                 r_out_zone;
    logic [LB-1:0]                  r_out_level;
    gli_pkg::t_feedback             r_out_fb;
    logic [SAMPLE_BITS-1:0]         r_out_low;
    logic [SAMPLE_BITS-1:0]         r_out_high;

    logic                           w_in_ready;
    logic                           w_div_start;
    logic                           w_out_load;
    logic                           w_div_done;
    logic [gli_pkg::QUO_BITS-1:0]   w_quo;
    logic [SAMPLE_BITS-1:0]         w_floor;
    logic [SAMPLE_BITS-1:0]         w_clamped;
    logic [NUM_BITS-1:0]            w_num;
    logic [SAMPLE_BITS-1:0]         w_den;
    logic [LB-1:0]                  w_level;
    logic [LB:0]                    w_lo_cmp;
    logic [LB:0]                    w_hi_cmp;
    gli_pkg::t_zone                 w_zone;

    gli_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    gli_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gli_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = gli_pkg::ST_CAL;
                end
            end
            gli_pkg::ST_CAL: begin
                n_state = gli_pkg::ST_PREP;
            end
            gli_pkg::ST_PREP: begin
                n_state = gli_pkg::ST_DIV;
            end
            gli_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = gli_pkg::ST_ZONE;
                end
            end
            gli_pkg::ST_ZONE: begin
                n_state = gli_pkg::ST_OUT;
            end
            gli_pkg::ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = gli_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gli_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: control outputs.
    always_comb begin
        w_in_ready  = (r_state == gli_pkg::ST_IDLE);
        w_div_start = (r_state == gli_pkg::ST_PREP);
        w_out_load  = (r_state == gli_pkg::ST_OUT) && (!r_out_valid || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gli_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Press counter and release action. A held button counts up and
    // saturates; the release tick decides by press length which action
    // runs, the set actions using this tick's sample.
    always_comb begin
        n_press    = r_press;
        n_cal_low  = r_cal_low;
        n_cal_high = r_cal_high;
        n_fb       = gli_pkg::FB_NONE;
        if (r_btn) begin
            if (!(&r_press)) begin
                n_press = r_press + 1'b1;
            end
        end else if (r_press != '0) begin
            priority if (r_press > w_cfg.reset_press) begin
                n_cal_low  = '0;
                n_cal_high = '1;
                n_fb       = gli_pkg::FB_DEFAULTS;
            end else if (r_press > w_cfg.long_press) begin
                if (r_sample > r_cal_low) begin
                    n_cal_high = r_sample;
                    n_fb       = gli_pkg::FB_HIGH_SET;
                end else begin
                    n_fb = gli_pkg::FB_REJECTED;
                end
            end else begin
                if (r_sample < r_cal_high) begin
                    n_cal_low = r_sample;
                    n_fb      = gli_pkg::FB_LOW_SET;
                end else begin
                    n_fb = gli_pkg::FB_REJECTED;
                end
            end
            n_press = '0;
        end
    end

    // Clamp the sample into the calibration span; the divider then finds
    // (sample - low) * 8 / (high - low).
    assign w_floor   = (r_sample < r_cal_low) ? r_cal_low : r_sample;
    assign w_clamped = (w_floor > r_cal_high) ? r_cal_high : w_floor;
    assign w_num     = {w_clamped - r_cal_low, gli_pkg::SCALE_SHIFT'(0)};
    assign w_den     = r_cal_high - r_cal_low;

    // An empty span cannot be reached from reset but still reads as level 1.
    assign w_level = r_empty ? gli_pkg::LEVEL_MIN : (LB'(w_quo) + gli_pkg::LEVEL_MIN);

    // Hysteresis: each bound drops by one while the last zone is the one just above it.
    // Adding one to the level instead keeps the compare unsigned.
    assign w_lo_cmp = {1'b0, w_level} + (LB+1)'(r_last_zone == gli_pkg::ZONE_YELLOW);
    assign w_hi_cmp = {1'b0, w_level} + (LB+1)'(r_last_zone == gli_pkg::ZONE_RED);

    always_comb begin
        priority if (w_lo_cmp < {1'b0, w_cfg.low_level}) begin
            w_zone = gli_pkg::ZONE_GREEN;
        end else if (w_hi_cmp < {1'b0, w_cfg.high_level}) begin
            w_zone = gli_pkg::ZONE_YELLOW;
        end else begin
            w_zone = gli_pkg::ZONE_RED;
        end
    end

    // Calibration, press counter and zone history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_low   <= '0;
            r_cal_high  <= '1;
            r_press     <= '0;
            r_last_zone <= gli_pkg::ZONE_GREEN;
        end else begin
            if (r_state == gli_pkg::ST_CAL) begin
                r_cal_low  <= n_cal_low;
                r_cal_high <= n_cal_high;
                r_press    <= n_press;
            end
            if (r_state == gli_pkg::ST_ZONE) begin
                r_last_zone <= w_zone;
            end
        end
    end

    // Per-item payload.
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_sample <= i_in.sample;
            r_btn    <= i_in.button_pressed;
        end
        if (r_state == gli_pkg::ST_CAL) begin
            r_fb <= n_fb;
        end
        if (r_state == gli_pkg::ST_PREP) begin
            r_empty <= (r_cal_high <= r_cal_low);
        end
        if (r_state == gli_pkg::ST_ZONE) begin
            r_level <= w_level;
            r_zone  <= w_zone;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_zone  <= r_zone;
            r_out_level <= r_level;
            r_out_fb    <= r_fb;
            r_out_low   <= r_cal_low;
            r_out_high  <= r_cal_high;
        end
    end

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.zone         = r_out_zone;
    assign o_out.level        = r_out_level;
    assign o_out.feedback     = r_out_fb;
    assign o_out.cal_low_out  = r_out_low;
    assign o_out.cal_high_out = r_out_high;

    `GLI_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in.valid && w_in_ready, r_state == gli_pkg::ST_CAL, "accepted beat did not start the sequence")
    `GLI_ASSERT_NOW(a_cal_order, i_clk, i_rst_n, 1'b1, r_cal_low < r_cal_high, "calibration span collapsed")
    `GLI_ASSERT_NOW(a_level_range, i_clk, i_rst_n, r_out_valid, (r_out_level >= gli_pkg::LEVEL_MIN) && (r_out_level <= gli_pkg::LEVEL_MAX), "level out of range")

endmodule

`default_nettype wire

@@ rtl/core/gli_cfg.sv @@
`default_nettype none

module gli_cfg (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    gli_cfg_if.sink       i_cfg,
    output gli_pkg::t_cfg o_cfg
);

    gli_pkg::t_cfg r_cfg;

    // Writes are always taken; an index past the register list is dropped.
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_level   <= gli_pkg::LOW_LEVEL_RST;
            r_cfg.high_level  <= gli_pkg::HIGH_LEVEL_RST;
            r_cfg.long_press  <= gli_pkg::LONG_PRESS_RST;
            r_cfg.reset_press <= gli_pkg::RESET_PRESS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                gli_pkg::CFG_LOW_LEVEL: begin
                    r_cfg.low_level <= i_cfg.data[gli_pkg::LEVEL_BITS-1:0];
                end
                gli_pkg::CFG_HIGH_LEVEL: begin
                    r_cfg.high_level <= i_cfg.data[gli_pkg::LEVEL_BITS-1:0];
                end
                gli_pkg::CFG_LONG_PRESS: begin
                    r_cfg.long_press <= i_cfg.data[gli_pkg::PRESS_BITS-1:0];
                end
                gli_pkg::CFG_RESET_PRESS: begin
                    r_cfg.reset_press <= i_cfg.data[gli_pkg::PRESS_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/gli_div.sv @@
`default_nettype none

`include "gas_level_indicator_with_calibration_assert.svh"

// Restoring divider for a quotient of at most QUO_MAX: one compare and
// subtract per cycle, most significant quotient bit first.
module gli_div #(
    parameter int SAMPLE_BITS = gli_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [SAMPLE_BITS+gli_pkg::SCALE_SHIFT-1:0] i_num,
    input  wire logic [SAMPLE_BITS-1:0]            i_den,
    output logic                                   o_done,
    output logic [gli_pkg::QUO_BITS-1:0]           o_quo
);

    localparam int NUM_BITS = SAMPLE_BITS + gli_pkg::SCALE_SHIFT;

    logic                             r_busy;
    logic                             r_done;
    logic [gli_pkg::STEP_BITS-1:0]    r_step;
    logic [NUM_BITS-1:0]              r_rem;
    logic [NUM_BITS-1:0]              r_den;
    logic [gli_pkg::QUO_BITS-1:0]     r_quo;
    logic [NUM_BITS-1:0]              w_shifted;
    logic                             w_fits;

    assign w_shifted = r_den << r_step;
    assign w_fits    = (r_rem >= w_shifted);
    assign o_done    = r_done;
    assign o_quo     = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= gli_pkg::STEP_BITS'(gli_pkg::QUO_BITS - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= NUM_BITS'(i_den);
            r_quo <= '0;
        end else if (r_busy && w_fits) begin
            r_rem         <= r_rem - w_shifted;
            r_quo[r_step] <= 1'b1;
        end
    end

    `GLI_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, i_start, !r_busy, "divider restarted while busy")
    `GLI_ASSERT_NOW(a_quo_range, i_clk, i_rst_n, r_done, r_quo <= gli_pkg::QUO_MAX, "quotient past span")

endmodule

`default_nettype wire

@@ bench/tb_gas_level_indicator_with_calibration.sv @@
`timescale 1ns / 1ps

module tb_gas_level_indicator_with_calibration;

    // The block runs at its default sample width, so samples are 10 bits wide.
    localparam int SB         = gli_pkg::SAMPLE_BITS_DEF;
    localparam int SAMPLE_TOP = (1 << SB) - 1;

    // Index writes at or above this one hit no register and must change nothing.
    localparam int CFG_FIRST_UNUSED = 4;
    localparam int CFG_LAST_UNUSED  = (1 << gli_pkg::CFG_IDX_BITS) - 1;

    // Idle cycles waited after the last result before the registers are touched.
    localparam int DRAIN_CYCLES    = 12;
    localparam int GAP_MAX         = 14;
    localparam int SQUEEZE_CYCLES  = 400;
    localparam int ITEMS_PER_PHASE = 260;
    // The cycle limit leaves ample room for the roughly 2000 beats of the run,
    // even with the longest gaps on both sides of every beat.
    localparam int CYCLE_LIMIT     = 500_000;

    // One result beat of the block, field by field.
    typedef struct packed {
        gli_pkg::t_zone                 zone;
        logic [gli_pkg::LEVEL_BITS-1:0] level;
        gli_pkg::t_feedback             feedback;
        logic [SB-1:0]                  cal_low;
        logic [SB-1:0]                  cal_high;
    } t_reading;

    localparam t_reading NO_READING = '0;

    // One row of the directed script. When retune is set, the script drains
    // the block and loads the short press thresholds before sending the row.
    // When typed is set, want is the result the row must produce.
    typedef struct {
        logic [SB-1:0] sample;
        logic          pressed;
        bit            retune;
        bit            typed;
        t_reading      want;
    } t_dial_row;

    // Thresholds of one program of the run.
    localparam gli_pkg::t_cfg CFG_DEFAULTS = '{gli_pkg::LOW_LEVEL_RST,
                                               gli_pkg::HIGH_LEVEL_RST,
                                               gli_pkg::LONG_PRESS_RST,
                                               gli_pkg::RESET_PRESS_RST};
    localparam gli_pkg::t_cfg CFG_QUICK    = '{4'd4, 4'd7, 16'd1, 16'd3};

    // Settings walked by the random part, extremes of every register included:
    // zero press thresholds (every press restores the defaults), the largest
    // press thresholds (every press is short), and level bounds of 0 and 15.
    localparam int N_PROGRAMS = 7;
    localparam gli_pkg::t_cfg PROGRAMS [N_PROGRAMS] = '{
        '{4'd4,  4'd7,  16'd10,    16'd100},
        '{4'd1,  4'd9,  16'd0,     16'd0},
        '{4'd0,  4'd15, 16'd3,     16'd8},
        '{4'd9,  4'd1,  16'd2,     16'd6},
        '{4'd3,  4'd5,  16'd65535, 16'd65535},
        '{4'd15, 4'd0,  16'd5,     16'd20},
        '{4'd2,  4'd8,  16'd1,     16'd4}
    };

    // Directed script. The first rows run on the reset thresholds and check
    // the reset state and the two ends of the sample range. The rest run on
    // the short press thresholds and walk every release action: low point
    // set, a sample below the low point, low point rejected at the high point,
    // high point set, high point rejected below the low point, defaults restored,
    // and a press of exactly the reset count, which still counts as long.
    localparam int N_SCRIPT = 24;
    t_dial_row script [N_SCRIPT] = '{
        '{10'd0,    1'b0, 1'b0, 1'b1,
          '{gli_pkg::ZONE_GREEN, 4'd1, gli_pkg::FB_NONE, 10'd0, 10'd1023}},
        '{10'd1023, 1'b0, 1'b0, 1'b1,
          '{gli_pkg::ZONE_RED,   4'd9, gli_pkg::FB_NONE, 10'd0, 10'd1023}},
        '{10'd512,  1'b0, 1'b0, 1'b0, NO_READING},
        '{10'd0,    1'b0, 1'b0, 1'b1,
          '{gli_pkg::ZONE_GREEN, 4'd1, gli_pkg::FB_NONE, 10'd0, 10'd1023}},
        '{10'd300,  1'b1, 1'b1, 1'b0, NO_READING},
        '{10'd300,  1'b0, 1'b0, 1'b0, NO_READING},
        '{10'd100,  1'b0, 1'b0, 1'b0, NO_READING},
        '{10'd1023, 1'b1, 1'b0, 1'b0, NO_READING},
        '{10'd1023, 1'b0, 1'b0, 1'b0, NO_READING},
        '{10'd0,    1'b1, 1'b0, 1'b0, NO_READING},
        '{10'd1023, 1'b1, 1'b0, 1'b0, NO_READING},
        '{10'd800,  1'b0, 1'b0, 1'b0, NO_READING},
        '{10'd0,    1'b1, 1'b0, 1'b0, NO_READING},
        '{10'd0,    1'b1, 1'b0, 1'b0, NO_READING},
        '{10'd100,  1'b0, 1'b0, 1'b0, NO_READING},
        '{10'd1023, 1'b1, 1'b0, 1'b0, NO_READING},
        '{10'd0,    1'b1, 1'b0, 1'b0, NO_READING},
        '{10'd512,  1'b1, 1'b0, 1'b0, NO_READING},
        '{10'd0,    1'b1, 1'b0, 1'b0, NO_READING},
        '{10'd500,  1'b0, 1'b0, 1'b0, NO_READING},
        '{10'd0,    1'b1, 1'b0, 1'b0, NO_READING},
        '{10'd0,    1'b1, 1'b0, 1'b0, NO_READING},
        '{10'd0,    1'b1, 1'b0, 1'b0, NO_READING},
        '{10'd900,  1'b0, 1'b0, 1'b0, NO_READING}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gli_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
    gli_out_if #(.SAMPLE_BITS(SB)) out_ch ();
    gli_cfg_if                     cfg_ch ();

    gas_level_indicator_with_calibration #(
        .SAMPLE_BITS(SB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // 12 ns period: 6 ns high, 6 ns low.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the indicator: thresholds, calibration span, press
    // counter and the zone of the previous tick.
    gli_pkg::t_cfg  gauge_cfg;
    logic [SB-1:0]  span_lo;
    logic [SB-1:0]  span_hi;
    logic [15:0]    hold_ticks;
    gli_pkg::t_zone prev_zone;

    // Readings owed by the block, oldest first.
    t_reading       readings_due [$];

    int  errors;
    int  beats_taken;

    // Flag from the stimulus side to the receiver: squeeze_req asks it for
    // one long hold-off.
    bit  squeeze_req;

    // Sender side idling: a quiet stretch with no gaps now and then.
    int  tx_count;
    bit  tx_calm;

    // Advance the shadow copy by one tick and return the reading it yields.
    function automatic t_reading gauge_tick(input logic [SB-1:0] s, input logic pressed);
        t_reading r;
        int       x;
        int       lvl;
        int       lo_b;
        int       hi_b;
        r = NO_READING;
        r.feedback = gli_pkg::FB_NONE;
        if (pressed) begin
            if (hold_ticks != 16'hFFFF) begin
                hold_ticks = hold_ticks + 16'd1;
            end
        end else if (hold_ticks != 16'd0) begin
            // The press length decides the action; the releasing tick's
            // sample is the candidate calibration point.
            if (hold_ticks > gauge_cfg.reset_press) begin
                span_lo    = '0;
                span_hi    = SB'(SAMPLE_TOP);
                r.feedback = gli_pkg::FB_DEFAULTS;
            end else if (hold_ticks > gauge_cfg.long_press) begin
                if (s > span_lo) begin
                    span_hi    = s;
                    r.feedback = gli_pkg::FB_HIGH_SET;
                end else begin
                    r.feedback = gli_pkg::FB_REJECTED;
                end
            end else begin
                if (s < span_hi) begin
                    span_lo    = s;
                    r.feedback = gli_pkg::FB_LOW_SET;
                end else begin
                    r.feedback = gli_pkg::FB_REJECTED;
                end
            end
            hold_ticks = 16'd0;
        end

        // Clamp to the span and scale to 1..9; an empty span reads as 1.
        if (span_hi <= span_lo) begin
            lvl = int'(gli_pkg::LEVEL_MIN);
        end else begin
            x = int'(s);
            if (x < int'(span_lo)) x = int'(span_lo);
            if (x > int'(span_hi)) x = int'(span_hi);
            lvl = (x - int'(span_lo))
                  * (int'(gli_pkg::LEVEL_MAX) - int'(gli_pkg::LEVEL_MIN))
                  / (int'(span_hi) - int'(span_lo)) + int'(gli_pkg::LEVEL_MIN);
        end

        // Hysteresis: each bound drops by one while the zone above it holds.
        lo_b = int'(gauge_cfg.low_level);
        hi_b = int'(gauge_cfg.high_level);
        if (prev_zone == gli_pkg::ZONE_YELLOW) begin
            lo_b = lo_b - 1;
        end else if (prev_zone == gli_pkg::ZONE_RED) begin
            hi_b = hi_b - 1;
        end
        if (lvl < lo_b) begin
            r.zone = gli_pkg::ZONE_GREEN;
        end else if (lvl < hi_b) begin
            r.zone = gli_pkg::ZONE_YELLOW;
        end else begin
            r.zone = gli_pkg::ZONE_RED;
        end
        prev_zone  = r.zone;
        r.level    = gli_pkg::LEVEL_BITS'(lvl);
        r.cal_low  = span_lo;
        r.cal_high = span_hi;
        return r;
    endfunction

    // A sample that leans toward the range ends and the calibration points,
    // so that rejections at the span edges come up often.
    function automatic logic [SB-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = SAMPLE_TOP;
            2: v = int'(span_lo) + int'($urandom_range(0, 2)) - 1;
            3: v = int'(span_hi) + int'($urandom_range(0, 2)) - 1;
            default: v = int'($urandom_range(0, SAMPLE_TOP));
        endcase
        if (v < 0) v = 0;
        if (v > SAMPLE_TOP) v = SAMPLE_TOP;
        return SB'(v);
    endfunction

    // Length of one press, aimed at a short, a long or a reset press under
    // the current thresholds. Very large thresholds are out of reach, so the
    // length is capped and such presses simply land in a lower class.
    function automatic int press_length();
        int lp;
        int rp;
        int len;
        lp = int'(gauge_cfg.long_press);
        rp = int'(gauge_cfg.reset_press);
        case ($urandom_range(0, 2))
            0: len = int'($urandom_range(1, (lp < 1) ? 1 : ((lp > 60) ? 60 : lp)));
            1: begin
                if (rp > lp) begin
                    len = lp + 1 + int'($urandom_range(0, (rp - lp - 1 > 40) ? 40 : rp - lp - 1));
                end else begin
                    len = lp + 1;
                end
            end
            default: len = rp + 1 + int'($urandom_range(0, 2));
        endcase
        if (len > 150) len = 150;
        if (len < 1) len = 1;
        return len;
    endfunction

    // Offer one input beat, entered and left at a falling edge. The gap goes
    // in front of the beat, so valid stays high across back-to-back beats.
    // On acceptance the shadow copy advances and the reading is queued.
    task automatic send_beat(input logic [SB-1:0] s, input logic pressed,
                             input bit typed, input t_reading want);
        int       gap;
        t_reading r;
        if (tx_count % 40 == 0) begin
            tx_calm = ($urandom_range(0, 3) == 0);
        end
        tx_count = tx_count + 1;
        gap = tx_calm ? 0 : int'($urandom_range(0, GAP_MAX));
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.sample         <= s;
        in_ch.button_pressed <= pressed;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        r = gauge_tick(s, pressed);
        readings_due.push_back(typed ? want : r);
        @(negedge i_clk);
    endtask

    // Wait until every owed reading has arrived, then let the block settle.
    task automatic drain();
        while (readings_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One register write, entered and left at a falling edge.
    task automatic cfg_write(input logic [gli_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [gli_pkg::CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            gli_pkg::CFG_LOW_LEVEL:   gauge_cfg.low_level   = value[gli_pkg::LEVEL_BITS-1:0];
            gli_pkg::CFG_HIGH_LEVEL:  gauge_cfg.high_level  = value[gli_pkg::LEVEL_BITS-1:0];
            gli_pkg::CFG_LONG_PRESS:  gauge_cfg.long_press  = value;
            gli_pkg::CFG_RESET_PRESS: gauge_cfg.reset_press = value;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Load a full program while the block is idle. The level registers get
    // random upper data bits, which the block must ignore, and one write goes
    // to an index that holds no register.
    task automatic load_program(input gli_pkg::t_cfg p);
        cfg_write(gli_pkg::CFG_LOW_LEVEL,
                  {gli_pkg::CFG_DATA_BITS'($urandom_range(0, 4095)) << gli_pkg::LEVEL_BITS}
                  | p.low_level);
        cfg_write(gli_pkg::CFG_HIGH_LEVEL,
                  {gli_pkg::CFG_DATA_BITS'($urandom_range(0, 4095)) << gli_pkg::LEVEL_BITS}
                  | p.high_level);
        cfg_write(gli_pkg::CFG_LONG_PRESS, p.long_press);
        cfg_write(gli_pkg::CFG_RESET_PRESS, p.reset_press);
        cfg_write(gli_pkg::CFG_IDX_BITS'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                  gli_pkg::CFG_DATA_BITS'($urandom_range(0, 65535)));
        cfg_ch.valid <= 1'b0;
    endtask

    // Random traffic under the current program. Most of it is whole presses
    // of random length with random samples, followed by a few idle ticks;
    // the rest is ticks with a random button level.
    task automatic random_phase(input int n_items);
        int sent;
        int len;
        int idle;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                send_beat(pick_sample(), 1'($urandom_range(0, 1)), 1'b0, NO_READING);
                sent = sent + 1;
            end else begin
                len = press_length();
                repeat (len) send_beat(pick_sample(), 1'b1, 1'b0, NO_READING);
                send_beat(pick_sample(), 1'b0, 1'b0, NO_READING);
                idle = int'($urandom_range(0, 4));
                repeat (idle) send_beat(pick_sample(), 1'b0, 1'b0, NO_READING);
                sent = sent + len + 1 + idle;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors = errors + 1;
        end
    endtask

    // Result monitor: every beat taken on the output channel is compared
    // with the oldest owed reading. Outputs are sampled at the rising edge,
    // before the block updates them.
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            beats_taken = beats_taken + 1;
            if (readings_due.size() == 0) begin
                $display("%0t: result beat with nothing owed, expected none, actual zone %0d level %0d",
                         $time, out_ch.zone, out_ch.level);
                errors = errors + 1;
            end else begin
                want = readings_due.pop_front();
                check_field("zone",     16'(want.zone),     16'(out_ch.zone));
                check_field("level",    16'(want.level),    16'(out_ch.level));
                check_field("feedback", 16'(want.feedback), 16'(out_ch.feedback));
                check_field("cal_low",  16'(want.cal_low),  16'(out_ch.cal_low_out));
                check_field("cal_high", 16'(want.cal_high), 16'(out_ch.cal_high_out));
            end
        end
    end

    // Receiver: after each taken beat it draws a stall of random length, with stall-free
    // stretches now and then. On request it holds off once for a long stretch
    // so the block fills up and stalls its input side.
    initial begin : receiver
        int  seen;
        int  rx_wait;
        bit  rx_calm;
        bit  squeeze_done;
        seen         = 0;
        rx_wait      = 0;
        rx_calm      = 1'b0;
        squeeze_done = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else begin
                if (beats_taken != seen) begin
                    seen = beats_taken;
                    if (seen % 40 == 0) begin
                        rx_calm = ($urandom_range(0, 3) == 0);
                    end
                    rx_wait = rx_calm ? 0 : int'($urandom_range(0, GAP_MAX));
                end
                if (squeeze_req && !squeeze_done && rx_wait == 0) begin
                    squeeze_done = 1'b1;
                    rx_wait      = SQUEEZE_CYCLES;
                end
                if (rx_wait > 0) begin
                    rx_wait = rx_wait - 1;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    // A run that hangs anywhere ends here.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles = cycles + 1;
        end
        $display("gas_level_indicator_with_calibration regression: fail");
        $finish;
    end

    // Main sequence: reset, directed script, then one random phase per
    // program, and the final verdict.
    initial begin : stimulus
        int i;
        in_ch.valid          = 1'b0;
        in_ch.sample         = '0;
        in_ch.button_pressed = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        errors      = 0;
        beats_taken = 0;
        squeeze_req = 1'b0;
        tx_count    = 0;
        tx_calm     = 1'b0;

        // The shadow copy starts from the reset state of the block.
        gauge_cfg  = CFG_DEFAULTS;
        span_lo    = '0;
        span_hi    = SB'(SAMPLE_TOP);
        hold_ticks = 16'd0;
        prev_zone  = gli_pkg::ZONE_GREEN;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed script.
        for (i = 0; i < N_SCRIPT; i++) begin
            if (script[i].retune) begin
                in_ch.valid <= 1'b0;
                drain();
                load_program(CFG_QUICK);
            end
            send_beat(script[i].sample, script[i].pressed, script[i].typed, script[i].want);
        end
        in_ch.valid <= 1'b0;
        drain();

        // Random phases, one per program. The long receiver hold-off comes
        // early in the second phase while the sender keeps offering beats.
        for (i = 0; i < N_PROGRAMS; i++) begin
            load_program(PROGRAMS[i]);
            if (i == 1) begin
                squeeze_req = 1'b1;
            end
            random_phase(ITEMS_PER_PHASE);
            in_ch.valid <= 1'b0;
            drain();
        end

        if (errors == 0 && readings_due.size() == 0) begin
            $display("gas_level_indicator_with_calibration regression: pass");
        end else begin
            $display("gas_level_indicator_with_calibration regression: fail");
        end
        $finish;
    end

endmodule

@@ gas_level_indicator_with_calibration.f @@
+incdir+rtl/core
rtl/core/gli_pkg.sv
rtl/core/gli_if.sv
rtl/core/gli_cfg.sv
rtl/core/gli_div.sv
rtl/core/gas_level_indicator_with_calibration.sv
bench/tb_gas_level_indicator_with_calibration.sv
